>>> design/bda_pkg.sv
// Shared constants, types and the shift-and-add-3 step for the decimal converter.
`default_nettype none
package bda_pkg;

	localparam int VALUE_W        = 32;
	localparam int DIGIT_COUNT    = 10;
	localparam int BITS_PER_STAGE = 4;
	localparam int NUM_STAGES     = VALUE_W / BITS_PER_STAGE;
	localparam int DIDX_W         = $clog2(DIGIT_COUNT);
	localparam logic [5:0] ASCII_ZERO = 6'd48;

	typedef logic [DIGIT_COUNT-1:0][3:0] bcd_t;

	// Run BITS_PER_STAGE double-dabble iterations, feeding bits MSB first.
	function automatic bcd_t dabble_stage(input bcd_t bcd_in,
			input logic [BITS_PER_STAGE-1:0] bits);
		logic [4*DIGIT_COUNT-1:0] flat;
		bcd_t b;
		b = bcd_in;
		for (int i = 0; i < BITS_PER_STAGE; i++) begin
			for (int d = 0; d < DIGIT_COUNT; d++) begin
				if (b[d] >= 4'd5) begin
					b[d] = b[d] + 4'd3;
				end
			end
			flat = b;
			flat = {flat[4*DIGIT_COUNT-2:0], bits[BITS_PER_STAGE-1-i]};
			b = flat;
		end
		return b;
	endfunction

endpackage
`default_nettype wire

>>> design/bda_if.sv
// Valid/ready channel interfaces for the input values and the digit characters.
`default_nettype none
interface bda_in_if import bda_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;
	logic               keep_leading_zeros;

	modport source (output valid, output value, output keep_leading_zeros, input ready);
	modport sink   (input valid, input value, input keep_leading_zeros, output ready);
endinterface

interface bda_out_if;
	logic       valid;
	logic       ready;
	logic [5:0] digit_char;
	logic       last_digit;

	modport source (output valid, output digit_char, output last_digit, input ready);
	modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface
`default_nettype wire

>>> design/binary_to_decimal_ascii.sv
// Binary to decimal ASCII converter: pipelined double dabble and a digit emitter.
//
// din carries one 32-bit unsigned value and a keep_leading_zeros flag per
// transaction. dout carries one ASCII digit ('0' to '9') per transaction,
// most significant first; last_digit marks the units digit that ends a run.
// With keep_leading_zeros set all ten digits go out; otherwise leading zeros
// are dropped and a zero value gives a single '0'.
// The value passes through 8 conversion stages of 4 shift-and-add-3 steps
// each, then loads the emitter register that drives dout. The emitter sends
// one digit per cycle while dout is ready, 1 to 10 digits per value; the
// next value loads in the cycle its predecessor's last digit is taken, so
// dout stays busy back to back. Up to 8 further values wait in the stages.
// When dout stalls, the emitter holds its digit; the stages keep advancing
// until a converted value reaches the last stage, then all stages hold and
// din ready falls. Reset clears all valid bits; no data is lost or repeated
// across a stall.
`default_nettype none
module binary_to_decimal_ascii import bda_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	bda_in_if.sink     din,
	bda_out_if.source  dout
);

	logic [NUM_STAGES-1:0] vld_s;
	logic                  keep_s [NUM_STAGES];
	bcd_t                  bcd_s  [NUM_STAGES];
	logic [VALUE_W-1:0]    bin_s  [NUM_STAGES];

	logic              busy_q;
	bcd_t              dig_q;
	logic [DIDX_W-1:0] pos_q;

	logic              out_take;
	logic              emit_done;
	logic              load;
	logic              adv;
	logic [DIDX_W-1:0] start_idx;
	bcd_t              last_bcd;

	assign out_take  = busy_q && dout.ready;
	assign emit_done = out_take && (pos_q == '0);
	assign load      = vld_s[NUM_STAGES-1] && (!busy_q || emit_done);
	assign adv       = !vld_s[NUM_STAGES-1] || load;
	assign din.ready = adv;

	assign last_bcd = bcd_s[NUM_STAGES-1];

	// Highest nonzero digit, or the units digit for zero; the top digit with keep_leading_zeros.
	always_comb begin
		start_idx = '0;
		for (int d = 1; d < DIGIT_COUNT; d++) begin
			if (last_bcd[d] != 4'd0) begin
				start_idx = DIDX_W'(d);
			end
		end
		if (keep_s[NUM_STAGES-1]) begin
			start_idx = DIDX_W'(DIGIT_COUNT - 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NUM_STAGES-2:0], din.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bcd_s[0]  <= dabble_stage('0, din.value[VALUE_W-1 -: BITS_PER_STAGE]);
			bin_s[0]  <= din.value << BITS_PER_STAGE;
			keep_s[0] <= din.keep_leading_zeros;
			for (int k = 1; k < NUM_STAGES; k++) begin
				bcd_s[k]  <= dabble_stage(bcd_s[k-1],
					bin_s[k-1][VALUE_W-1 -: BITS_PER_STAGE]);
				bin_s[k]  <= bin_s[k-1] << BITS_PER_STAGE;
				keep_s[k] <= keep_s[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			pos_q  <= start_idx;
		end else if (emit_done) begin
			busy_q <= 1'b0;
		end else if (out_take) begin
			pos_q <= pos_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dig_q <= last_bcd;
		end
	end

	assign dout.valid      = busy_q;
	assign dout.digit_char = ASCII_ZERO + {2'b00, dig_q[pos_q]};
	assign dout.last_digit = (pos_q == '0);

endmodule
`default_nettype wire
